// ----- rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Transaction payload types, sector codes, scaling constants and the hue
// decode function that the converter modules share.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HueW       = 9;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned RemW       = 6;
  localparam int unsigned CntW       = 4;
  localparam int unsigned TermW      = 14;
  localparam int unsigned ProdW      = TermW + ChanW;
  localparam int unsigned RecipW     = 19;
  localparam int unsigned RecipShift = 32;
  localparam int unsigned NumStages  = 5;

  localparam int unsigned SectorDeg   = 60;
  localparam int unsigned FullScale   = 255;
  localparam int unsigned SectorScale = SectorDeg * FullScale;
  localparam int unsigned SectorCount = 8;
  localparam logic [RecipW-1:0] RecipMul = RecipW'((64'd1 << RecipShift) / SectorScale);

  typedef enum logic [2:0] {
    SEC_RED_YELLOW     = 3'd0,
    SEC_YELLOW_GREEN   = 3'd1,
    SEC_GREEN_CYAN     = 3'd2,
    SEC_CYAN_BLUE      = 3'd3,
    SEC_BLUE_MAGENTA   = 3'd4,
    SEC_MAGENTA_RED    = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HueW-1:0]  hue_deg;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_out_t;

  typedef struct packed {
    sector_t         sector;
    logic [RemW-1:0] rem;
  } hue_split_t;

  function automatic hue_split_t hue_split(input logic [HueW-1:0] hue);
    logic [CntW-1:0] cnt;
    logic [HueW-1:0] base;
    hue_split_t      res;
    cnt  = '0;
    base = '0;
    for (int i = 1; i <= SectorCount; i++) begin
      if (hue >= HueW'(i * SectorDeg)) begin
        cnt  = CntW'(i);
        base = HueW'(i * SectorDeg);
      end
    end
    if (cnt >= CntW'(SEC_MAGENTA_RED)) begin
      res.sector = SEC_MAGENTA_RED;
    end else begin
      res.sector = sector_t'(cnt[2:0]);
    end
    res.rem = RemW'(hue - base);
    return res;
  endfunction

endpackage

// ----- rtl/hsv2rgb_cdiv.sv -----
// ----------------------------------------------------------------------------
// Constant divider
// Floor division by the sector scale: a registered reciprocal multiply gives
// an estimate that is exact or one low, and a compare and add after the
// register corrects it in the following stage.
// ----------------------------------------------------------------------------
module hsv2rgb_cdiv
  import hsv2rgb_pkg::*;
(
  input  logic              clk,
  input  logic              ld,
  input  logic [ProdW-1:0]  x,
  output logic [ChanW-1:0]  quo
);

  logic [ProdW-1:0]        x_r;
  logic [ChanW-1:0]        est_r;
  logic [ProdW+RecipW-1:0] scaled;
  logic [ChanW-1:0]        est_nxt;
  logic [ProdW-1:0]        resid;

  assign scaled  = (ProdW+RecipW)'(x) * (ProdW+RecipW)'(RecipMul);
  assign est_nxt = scaled[RecipShift +: ChanW];

  assign resid   = x_r - ProdW'(est_r) * ProdW'(SectorScale);

  always_ff @(posedge clk) begin
    if (ld) begin
      x_r   <= x;
      est_r <= est_nxt;
    end
  end

  assign quo = (resid >= ProdW'(SectorScale)) ? est_r + ChanW'(1) : est_r;

endmodule

// ----- rtl/hsv_to_rgb_converter_core.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Each transaction carries one HSV color; the core returns one RGB color.
// The core takes one transaction per clock unless in_stall holds it off. The
// five register stages are hue decode, saturation products, brightness
// products, reciprocal divide estimate, and divide correction with channel
// select. Each stage holds its data while stalled and fills bubbles ahead of
// a stall.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hsv_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rgb_out_t out_data
);

  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] vld_nxt;
  logic [NumStages-1:0] rdy;

  sector_t          sec1_r, sec2_r, sec3_r, sec4_r;
  logic [RemW-1:0]  rem1_r;
  logic [ChanW-1:0] sat1_r;
  logic [ChanW-1:0] val1_r, val2_r, val3_r, val4_r;
  logic [TermW-1:0] aq2_r, at2_r;
  logic [ChanW-1:0] np2_r;
  logic [ProdW-1:0] xq3_r, xt3_r;
  logic [15:0]      xp3_r;
  logic [ChanW-1:0] p4_r;
  rgb_out_t         out_r;

  hue_split_t       split1;
  logic [TermW-1:0] aq2_nxt, at2_nxt;
  logic [RemW:0]    comp;
  logic [16:0]      psum;
  logic [ChanW-1:0] q_div, t_div;
  rgb_out_t         out_nxt;

  always_comb begin
    rdy[NumStages-1] = !vld_r[NumStages-1] || !out_stall;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign split1  = hue_split(in_data.hue_deg);
  assign comp    = (RemW+1)'(SectorDeg) - (RemW+1)'(rem1_r);
  assign aq2_nxt = TermW'(SectorScale) - TermW'(sat1_r) * TermW'(rem1_r);
  assign at2_nxt = TermW'(SectorScale) - TermW'(sat1_r) * TermW'(comp);
  assign psum    = 17'(xp3_r) + 17'(xp3_r[15:8]) + 17'd1;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sec1_r <= split1.sector;
      rem1_r <= split1.rem;
      sat1_r <= in_data.saturation;
      val1_r <= in_data.brightness;
    end
    if (rdy[1]) begin
      sec2_r <= sec1_r;
      val2_r <= val1_r;
      aq2_r  <= aq2_nxt;
      at2_r  <= at2_nxt;
      np2_r  <= ~sat1_r;
    end
    if (rdy[2]) begin
      sec3_r <= sec2_r;
      val3_r <= val2_r;
      xq3_r  <= ProdW'(val2_r) * ProdW'(aq2_r);
      xt3_r  <= ProdW'(val2_r) * ProdW'(at2_r);
      xp3_r  <= 16'(val2_r) * 16'(np2_r);
    end
    if (rdy[3]) begin
      sec4_r <= sec3_r;
      val4_r <= val3_r;
      p4_r   <= psum[15:8];
    end
    if (rdy[4]) begin
      out_r  <= out_nxt;
    end
  end

  hsv2rgb_cdiv u_div_q (
    .clk  (clk),
    .ld   (rdy[3]),
    .x    (xq3_r),
    .quo  (q_div)
  );

  hsv2rgb_cdiv u_div_t (
    .clk  (clk),
    .ld   (rdy[3]),
    .x    (xt3_r),
    .quo  (t_div)
  );

  // The divider outputs are corrected in the same stage that holds the
  // stage-four brightness, p term and sector, so the select uses them directly.
  rgb_out_t sel_nxt;
  logic [ChanW-1:0] q_sel, t_sel;

  assign q_sel = q_div;
  assign t_sel = t_div;

  always_comb begin
    case (sec4_r)
      SEC_RED_YELLOW:   sel_nxt = '{red: val4_r, green: t_sel,  blue: p4_r};
      SEC_YELLOW_GREEN: sel_nxt = '{red: q_sel,  green: val4_r, blue: p4_r};
      SEC_GREEN_CYAN:   sel_nxt = '{red: p4_r,   green: val4_r, blue: t_sel};
      SEC_CYAN_BLUE:    sel_nxt = '{red: p4_r,   green: q_sel,  blue: val4_r};
      SEC_BLUE_MAGENTA: sel_nxt = '{red: t_sel,  green: p4_r,   blue: val4_r};
      default:          sel_nxt = '{red: val4_r, green: p4_r,   blue: q_sel};
    endcase
  end

  assign out_nxt   = sel_nxt;
  assign out_valid = vld_r[NumStages-1];
  assign out_data  = out_r;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter core testbench
// Drives HSV colors through the valid/stall input channel and checks every
// RGB result against an integer predictor of the conversion, in order. The
// run covers directed corner colors, random colors under several idle and
// stall mixes, and a long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import hsv2rgb_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldOffCycles = 60;

  class color_scoreboard;
    rgb_out_t expected_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function automatic rgb_out_t convert(hsv_in_t c);
      int unsigned sec_num;
      int unsigned rem;
      int unsigned sat;
      int unsigned v;
      int unsigned p;
      int unsigned q;
      int unsigned t;
      sector_t     sector;
      rgb_out_t    res;
      sec_num = c.hue_deg / SectorDeg;
      rem     = c.hue_deg % SectorDeg;
      sat     = c.saturation;
      v       = c.brightness;
      p = (v * (FullScale - sat)) / FullScale;
      q = (v * (SectorScale - sat * rem)) / SectorScale;
      t = (v * (SectorScale - sat * (SectorDeg - rem))) / SectorScale;
      if (sec_num >= 5) begin
        sector = SEC_MAGENTA_RED;
      end else begin
        sector = sector_t'(sec_num[2:0]);
      end
      case (sector)
        SEC_RED_YELLOW: begin
          res.red = v[7:0]; res.green = t[7:0]; res.blue = p[7:0];
        end
        SEC_YELLOW_GREEN: begin
          res.red = q[7:0]; res.green = v[7:0]; res.blue = p[7:0];
        end
        SEC_GREEN_CYAN: begin
          res.red = p[7:0]; res.green = v[7:0]; res.blue = t[7:0];
        end
        SEC_CYAN_BLUE: begin
          res.red = p[7:0]; res.green = q[7:0]; res.blue = v[7:0];
        end
        SEC_BLUE_MAGENTA: begin
          res.red = t[7:0]; res.green = p[7:0]; res.blue = v[7:0];
        end
        default: begin
          res.red = v[7:0]; res.green = p[7:0]; res.blue = q[7:0];
        end
      endcase
      return res;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_input(hsv_in_t c);
      expected_q.push_back(convert(c));
    endfunction

    task check_result(rgb_out_t got);
      rgb_out_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        exp = expected_q.pop_front();
        if (got.red != exp.red)
          report($sformatf("red got %0d expected %0d", got.red, exp.red));
        if (got.green != exp.green)
          report($sformatf("green got %0d expected %0d", got.green, exp.green));
        if (got.blue != exp.blue)
          report($sformatf("blue got %0d expected %0d", got.blue, exp.blue));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hsv_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rgb_out_t out_data;

  color_scoreboard sb;
  int unsigned     idle_in_pct;
  int unsigned     stall_pct;
  logic            hold_off;
  int unsigned     quiet_cycles = 0;

  hsv_to_rgb_converter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IdleLimit) begin
          $display("[hsv_to_rgb_converter_core] ERROR");
          $finish;
        end
      end
    end
  end

  task send_color(input hsv_in_t c);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    sb.note_input(c);
    @(negedge clk);
  endtask

  task send_hsv(input int unsigned h, input int unsigned s, input int unsigned v);
    hsv_in_t c;
    c.hue_deg    = h[8:0];
    c.saturation = s[7:0];
    c.brightness = v[7:0];
    send_color(c);
  endtask

  function automatic int unsigned pick_channel();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  task send_random_colors(input int count);
    int unsigned h;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(7) == 0) begin
        h = $urandom_range(511, 360);
      end else begin
        h = $urandom_range(359);
      end
      send_hsv(h, pick_channel(), pick_channel());
    end
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    hold_off     = 1'b0;
    idle_in_pct  = 0;
    stall_pct    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_hsv(0, 255, 255);
    send_hsv(0, 0, 0);
    send_hsv(59, 255, 255);
    send_hsv(60, 255, 255);
    send_hsv(119, 200, 180);
    send_hsv(120, 255, 255);
    send_hsv(179, 128, 255);
    send_hsv(180, 255, 255);
    send_hsv(239, 255, 1);
    send_hsv(240, 255, 255);
    send_hsv(299, 77, 255);
    send_hsv(300, 255, 255);
    send_hsv(359, 255, 255);
    send_hsv(200, 0, 200);
    send_hsv(30, 0, 255);
    send_hsv(90, 255, 0);
    send_hsv(360, 255, 255);
    send_hsv(419, 200, 150);
    send_hsv(420, 255, 255);
    send_hsv(480, 128, 255);
    send_hsv(511, 255, 255);
    send_hsv(511, 0, 0);
    send_hsv(256, 170, 85);

    send_random_colors(200);
    idle_in_pct = 75;
    send_random_colors(170);
    idle_in_pct = 0;
    stall_pct   = 75;
    send_random_colors(170);
    idle_in_pct = 32;
    stall_pct   = 32;
    send_random_colors(170);

    idle_in_pct = 0;
    stall_pct   = 0;
    fork
      begin
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    send_random_colors(100);
    idle_in_pct = 10;
    stall_pct   = 10;
    send_random_colors(60);

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[hsv_to_rgb_converter_core] OK");
    end else begin
      $display("[hsv_to_rgb_converter_core] ERROR");
    end
    $finish;
  end

endmodule
